### rtl/gmf_pkg.sv
// ----------------------------------------------------------------------------
// gmf_pkg
// Shared types, constants and helpers for the grid maze frontier generator.
// ----------------------------------------------------------------------------
`default_nettype none

package gmf_pkg;

	localparam int MAX_SIDE  = 64;
	localparam int COORD_W   = $clog2(MAX_SIDE);
	localparam int NCELLS    = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W    = $clog2(NCELLS);
	localparam int COUNT_W   = ADDR_W + 1;
	localparam int SIDE_W    = 7;
	localparam int RAND_W    = 6;
	localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd32;
	localparam logic [SIDE_W-1:0] SIDE_MIN   = 7'd2;
	localparam logic [SIDE_W-1:0] SIDE_MAX   = 7'd64;

	localparam logic [1:0] CELL_OPEN  = 2'd0;
	localparam logic [1:0] CELL_WALL  = 2'd1;
	localparam logic [1:0] CELL_FRONT = 2'd2;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	localparam logic [1:0] DIR_UP = 2'd0;
	localparam logic [1:0] DIR_DN = 2'd1;
	localparam logic [1:0] DIR_LF = 2'd2;
	localparam logic [1:0] DIR_RT = 2'd3;

	typedef struct packed {
		logic                kind;
		logic [COORD_W-1:0]  start_row;
		logic [COORD_W-1:0]  start_col;
		logic [RAND_W-1:0]   random_value;
	} in_beat_t;

	typedef struct packed {
		logic [COORD_W-1:0]  cell_row;
		logic [COORD_W-1:0]  cell_col;
		logic                opened;
		logic [COUNT_W-1:0]  frontier_left;
		logic                done_res;
	} out_beat_t;

	// neighbour visiting order: start items down/up/right/left, steps up/down/left/right
	function automatic logic [1:0] nb_dir(input logic kind, input logic [1:0] n);
		logic [1:0] d;
		d = DIR_UP;
		if (kind == KIND_START) begin
			case (n)
				2'd0: d = DIR_DN;
				2'd1: d = DIR_UP;
				2'd2: d = DIR_RT;
				default: d = DIR_LF;
			endcase
		end else begin
			case (n)
				2'd0: d = DIR_UP;
				2'd1: d = DIR_DN;
				2'd2: d = DIR_LF;
				default: d = DIR_RT;
			endcase
		end
		return d;
	endfunction

endpackage

`default_nettype wire

### rtl/gmf_modu.sv
// ----------------------------------------------------------------------------
// gmf_modu
// Iterative remainder unit: one compare and subtract per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gmf_modu import gmf_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [RAND_W-1:0]  dividend,
	input  wire logic [COUNT_W-1:0] divisor,
	output logic                    done,
	output logic [COUNT_W-1:0]      rem
);

	logic [COUNT_W-1:0] rem_q;
	logic               run_q;
	logic               ge;

	assign ge   = rem_q >= divisor;
	assign done = run_q && !ge;
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (start) begin
			run_q <= 1'b1;
		end else if (done) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= COUNT_W'(dividend);
		end else if (run_q && ge) begin
			rem_q <= rem_q - divisor;
		end
	end

endmodule

`default_nettype wire

### rtl/grid_maze_frontier_generator.sv
// ----------------------------------------------------------------------------
// grid_maze_frontier_generator
// Randomised Prim maze generator over a grid of up to 64x64 cells with frontier list.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// in        input      in_valid/in_stall  in_data  (in_beat_t)
// out       output     out_valid/out_stall out_data (out_beat_t)
// cfg       input      cfg_wr_en          cfg_wr_data (grid side)
//
// Start beat: sweep of the whole 64x64 grid to walls, centre and start cell
// opened, neighbours read and appended, then the out register is loaded.
// Step beat: remainder of the random value by the list count, pick read, list
// shift from the pick to the end, neighbour reads and appends; the shift is
// bound by the single list write port. An empty list goes straight to output.
// No beat is taken until the previous result is loaded into the out register.
// Reset clears control state only; the grid is rebuilt by each start beat.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_maze_frontier_generator import gmf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire in_beat_t          in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output out_beat_t              out_data,
	input  wire logic              cfg_wr_en,
	input  wire logic [SIDE_W-1:0] cfg_wr_data
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLEAR = 4'd1;
	localparam logic [3:0] S_CEN   = 4'd2;
	localparam logic [3:0] S_SOP   = 4'd3;
	localparam logic [3:0] S_MOD   = 4'd4;
	localparam logic [3:0] S_PRD   = 4'd5;
	localparam logic [3:0] S_PWT   = 4'd6;
	localparam logic [3:0] S_SHIFT = 4'd7;
	localparam logic [3:0] S_NRD   = 4'd8;
	localparam logic [3:0] S_NEV   = 4'd9;
	localparam logic [3:0] S_OPEN  = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	logic [1:0]        grid_mem [NCELLS];
	logic [ADDR_W-1:0] list_mem [NCELLS];

	logic [3:0]          state_q;
	logic [SIDE_W-1:0]   side_cfg_q;
	logic [COUNT_W-1:0]  count_q;
	logic                kind_q;
	logic [COORD_W-1:0]  row_q, col_q;
	logic                opened_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [ADDR_W-1:0]   pick_q;
	logic [COUNT_W-1:0]  rd_q;
	logic                pend_s1;
	logic [ADDR_W-1:0]   wa_s1;
	logic                push_q;
	logic [1:0]          n_q;
	logic [2:0]          paths_q;
	logic                out_valid_q;
	out_beat_t           out_q;
	logic [1:0]          grid_rd_q;
	logic [ADDR_W-1:0]   list_rd_q;

	logic [SIDE_W-1:0]   side;
	logic                accept;
	logic [COORD_W-1:0]  srow, scol;
	logic [1:0]          dir;
	logic [SIDE_W-1:0]   nr, nc;
	logic                inb;
	logic [ADDR_W-1:0]   nb_addr;
	logic                grid_we;
	logic [ADDR_W-1:0]   grid_wa;
	logic [1:0]          grid_wd;
	logic                list_we;
	logic [ADDR_W-1:0]   list_wa;
	logic [ADDR_W-1:0]   list_wd;
	logic [ADDR_W-1:0]   list_ra;
	logic                mod_start;
	logic                mod_done;
	logic [COUNT_W-1:0]  mod_rem;
	logic                out_free;
	logic                push_ok;

	assign side = (side_cfg_q < SIDE_MIN) ? SIDE_MIN :
	              (side_cfg_q > SIDE_MAX) ? SIDE_MAX : side_cfg_q;

	assign in_stall  = state_q != S_IDLE;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign srow = ({1'b0, in_data.start_row} >= side) ? COORD_W'(side - 1'b1)
	                                                 : in_data.start_row;
	assign scol = ({1'b0, in_data.start_col} >= side) ? COORD_W'(side - 1'b1)
	                                                 : in_data.start_col;

	assign dir = nb_dir(kind_q, n_q);
	assign nr  = (dir == DIR_DN) ? {1'b0, row_q} + 1'b1 :
	             (dir == DIR_UP) ? {1'b0, row_q} - 1'b1 : {1'b0, row_q};
	assign nc  = (dir == DIR_RT) ? {1'b0, col_q} + 1'b1 :
	             (dir == DIR_LF) ? {1'b0, col_q} - 1'b1 : {1'b0, col_q};
	assign inb     = (nr < side) && (nc < side);
	assign nb_addr = {nr[COORD_W-1:0], nc[COORD_W-1:0]};
	assign push_ok = push_q && (grid_rd_q == CELL_WALL) && (count_q != COUNT_W'(NCELLS));

	assign mod_start = accept && in_data.kind == KIND_STEP && count_q != '0;

	gmf_modu u_modu (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (in_data.random_value),
		.divisor  (count_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_comb begin
		grid_we = 1'b0;
		grid_wa = nb_addr;
		grid_wd = CELL_FRONT;
		unique case (state_q)
			S_CLEAR: begin
				grid_we = 1'b1;
				grid_wa = clr_q;
				grid_wd = CELL_WALL;
			end
			S_CEN: begin
				grid_we = 1'b1;
				grid_wa = {side[COORD_W:1], side[COORD_W:1]};
				grid_wd = CELL_OPEN;
			end
			S_SOP, S_OPEN: begin
				grid_we = 1'b1;
				grid_wa = {row_q, col_q};
				grid_wd = CELL_OPEN;
			end
			S_NEV: grid_we = push_ok;
			default: grid_we = 1'b0;
		endcase
	end

	always_comb begin
		list_we = 1'b0;
		list_wa = wa_s1;
		list_wd = list_rd_q;
		if (state_q == S_SHIFT && pend_s1) begin
			list_we = 1'b1;
		end else if (state_q == S_NEV && push_ok) begin
			list_we = 1'b1;
			list_wa = count_q[ADDR_W-1:0];
			list_wd = nb_addr;
		end
		list_ra = (state_q == S_PRD) ? pick_q : rd_q[ADDR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (grid_we) begin
			grid_mem[grid_wa] <= grid_wd;
		end
		grid_rd_q <= grid_mem[nb_addr];
		if (list_we) begin
			list_mem[list_wa] <= list_wd;
		end
		list_rd_q <= list_mem[list_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			side_cfg_q  <= SIDE_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			pend_s1     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				side_cfg_q <= cfg_wr_data;
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q <= in_data.kind;
						if (in_data.kind == KIND_START) begin
							row_q    <= srow;
							col_q    <= scol;
							opened_q <= 1'b1;
							count_q  <= '0;
							clr_q    <= '0;
							state_q  <= S_CLEAR;
						end else begin
							opened_q <= 1'b0;
							row_q    <= '0;
							col_q    <= '0;
							state_q  <= (count_q == '0) ? S_OUT : S_MOD;
						end
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_CEN;
					end
				end
				S_CEN: state_q <= S_SOP;
				S_SOP: begin
					push_q  <= 1'b1;
					n_q     <= '0;
					state_q <= S_NRD;
				end
				S_MOD: begin
					if (mod_done) begin
						pick_q  <= mod_rem[ADDR_W-1:0];
						state_q <= S_PRD;
					end
				end
				S_PRD: state_q <= S_PWT;
				S_PWT: begin
					row_q   <= list_rd_q[ADDR_W-1:COORD_W];
					col_q   <= list_rd_q[COORD_W-1:0];
					rd_q    <= COUNT_W'(pick_q) + 1'b1;
					pend_s1 <= 1'b0;
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (rd_q < count_q) begin
						rd_q    <= rd_q + 1'b1;
						wa_s1   <= ADDR_W'(rd_q - 1'b1);
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							count_q <= count_q - 1'b1;
							push_q  <= 1'b0;
							n_q     <= '0;
							paths_q <= '0;
							state_q <= S_NRD;
						end
					end
				end
				S_NRD: begin
					if (inb) begin
						state_q <= S_NEV;
					end else if (n_q == 2'd3) begin
						state_q <= (!push_q) ? ((paths_q == 3'd1) ? S_OPEN : S_OUT) : S_OUT;
					end else begin
						n_q <= n_q + 1'b1;
					end
				end
				S_NEV: begin
					if (!push_q && grid_rd_q == CELL_OPEN) begin
						paths_q <= paths_q + 1'b1;
					end
					if (push_ok) begin
						count_q <= count_q + 1'b1;
					end
					if (n_q == 2'd3) begin
						if (!push_q && (paths_q + ((grid_rd_q == CELL_OPEN) ? 3'd1 : 3'd0)) == 3'd1)
							state_q <= S_OPEN;
						else
							state_q <= S_OUT;
					end else begin
						n_q     <= n_q + 1'b1;
						state_q <= S_NRD;
					end
				end
				S_OPEN: begin
					opened_q <= 1'b1;
					push_q   <= 1'b1;
					n_q      <= '0;
					state_q  <= S_NRD;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_q.cell_row      <= row_q;
			out_q.cell_col      <= col_q;
			out_q.opened        <= opened_q;
			out_q.frontier_left <= count_q;
			out_q.done_res      <= count_q == '0;
		end
	end

endmodule

`default_nettype wire
